### hw/rtl/rvcc_pkg.sv
// Shared opcodes, funct codes and result class codes for the RVC
// compressibility classifier. No dependencies.
package rvcc_pkg;

    localparam int unsigned INSTR_W = 32;
    localparam int unsigned CLASS_W = 5;

    typedef logic [INSTR_W-1:0] instr_t;
    typedef logic [CLASS_W-1:0] class_t;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    // Result classes
    localparam class_t CLS_NONE       = 5'd0;
    localparam class_t CLS_ADD        = 5'd1;
    localparam class_t CLS_MV         = 5'd2;
    localparam class_t CLS_AND        = 5'd3;
    localparam class_t CLS_OR         = 5'd4;
    localparam class_t CLS_XOR        = 5'd5;
    localparam class_t CLS_SUB        = 5'd6;
    localparam class_t CLS_JR         = 5'd7;
    localparam class_t CLS_JALR       = 5'd8;
    localparam class_t CLS_LI         = 5'd9;
    localparam class_t CLS_ADDI       = 5'd10;
    localparam class_t CLS_SLLI       = 5'd11;
    localparam class_t CLS_SRLI       = 5'd12;
    localparam class_t CLS_SRAI       = 5'd13;
    localparam class_t CLS_ANDI       = 5'd14;
    localparam class_t CLS_LUI        = 5'd15;
    localparam class_t CLS_LW         = 5'd16;
    localparam class_t CLS_SW         = 5'd17;
    localparam class_t CLS_BEQZ       = 5'd18;
    localparam class_t CLS_BNEZ       = 5'd19;
    localparam class_t CLS_J          = 5'd20;
    localparam class_t CLS_JAL        = 5'd21;
    localparam class_t CLS_BRANCH_FIX = 5'd22;
    localparam class_t CLS_JAL_FIX    = 5'd23;

endpackage

### hw/rtl/rvcc_classify.sv
// Combinational field decode and range checks for one instruction word.
// Depends on rvcc_pkg.
module rvcc_classify
(
    input  rvcc_pkg::instr_t instruction,
    output rvcc_pkg::class_t compress_class
);

    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic       rd_prime;
    logic       rs1_prime;
    logic       rs2_prime;
    logic       rs1_is_rd;
    logic       imm_i_small;   // I-immediate in -32..31
    logic       imm_i_zero;
    logic       imm_u_small;   // U-immediate in -32..31
    logic       imm_u_zero;
    logic       lw_offset_ok;  // 0..127, word aligned
    logic       sw_offset_ok;
    logic       br_offset_ok;  // -256..255
    logic       jal_offset_ok; // -2048..2047
    logic [4:0] br_top;
    logic [9:0] jal_top;

    assign op  = instruction[6:0];
    assign f3  = instruction[14:12];
    assign f7  = instruction[31:25];
    assign rd  = instruction[11:7];
    assign rs1 = instruction[19:15];
    assign rs2 = instruction[24:20];

    assign rd_prime  = (rd[4:3] == 2'b01);
    assign rs1_prime = (rs1[4:3] == 2'b01);
    assign rs2_prime = (rs2[4:3] == 2'b01);
    assign rs1_is_rd = (rs1 == rd);

    assign imm_i_small = (instruction[31:25] == 7'h00) || (instruction[31:25] == 7'h7f);
    assign imm_i_zero  = (instruction[31:20] == 12'h000);
    assign imm_u_small = (instruction[31:17] == 15'h0000) || (instruction[31:17] == 15'h7fff);
    assign imm_u_zero  = (instruction[31:12] == 20'h00000);

    assign lw_offset_ok = (instruction[31:27] == 5'h00) && (instruction[21:20] == 2'b00);
    assign sw_offset_ok = (instruction[31:27] == 5'h00) && (instruction[8:7] == 2'b00);

    // sign and upper offset bits must all agree
    assign br_top  = {instruction[31], instruction[7], instruction[30:28]};
    assign jal_top = {instruction[31], instruction[19:12], instruction[20]};
    assign br_offset_ok  = (br_top == 5'h00) || (br_top == 5'h1f);
    assign jal_offset_ok = (jal_top == 10'h000) || (jal_top == 10'h3ff);

    always_comb
    begin
        compress_class = rvcc_pkg::CLS_NONE;
        case (op)
            rvcc_pkg::OPC_OP:
            begin
                if (f3 == rvcc_pkg::F3_ADD)
                begin
                    if (f7 == rvcc_pkg::F7_ALT)
                    begin
                        if (rs2_prime && rd_prime && rs1_is_rd)
                            compress_class = rvcc_pkg::CLS_SUB;
                    end
                    else if (f7 == rvcc_pkg::F7_BASE)
                    begin
                        if (rs2 != rvcc_pkg::REG_ZERO && rd != rvcc_pkg::REG_ZERO)
                        begin
                            if (rs1 == rvcc_pkg::REG_ZERO)
                                compress_class = rvcc_pkg::CLS_MV;
                            else if (rs1_is_rd)
                                compress_class = rvcc_pkg::CLS_ADD;
                        end
                    end
                end
                else if (rs2_prime && rd_prime && rs1_is_rd && f7 == rvcc_pkg::F7_BASE)
                begin
                    if (f3 == rvcc_pkg::F3_AND)
                        compress_class = rvcc_pkg::CLS_AND;
                    else if (f3 == rvcc_pkg::F3_OR)
                        compress_class = rvcc_pkg::CLS_OR;
                    else if (f3 == rvcc_pkg::F3_XOR)
                        compress_class = rvcc_pkg::CLS_XOR;
                end
            end
            rvcc_pkg::OPC_JALR:
            begin
                if (rs1 != rvcc_pkg::REG_ZERO && imm_i_zero && f3 == rvcc_pkg::F3_ADD)
                begin
                    if (rd == rvcc_pkg::REG_ZERO)
                        compress_class = rvcc_pkg::CLS_JR;
                    else if (rd == rvcc_pkg::REG_RA)
                        compress_class = rvcc_pkg::CLS_JALR;
                end
            end
            rvcc_pkg::OPC_OPIMM:
            begin
                if (f3 == rvcc_pkg::F3_ADD)
                begin
                    if (rd != rvcc_pkg::REG_ZERO && imm_i_small)
                    begin
                        if (rs1 == rvcc_pkg::REG_ZERO)
                            compress_class = rvcc_pkg::CLS_LI;
                        else if (rs1_is_rd && !imm_i_zero)
                            compress_class = rvcc_pkg::CLS_ADDI;
                    end
                end
                else if (rs1_is_rd)
                begin
                    if (f3 == rvcc_pkg::F3_SLL && f7 == rvcc_pkg::F7_BASE
                        && rd != rvcc_pkg::REG_ZERO)
                        compress_class = rvcc_pkg::CLS_SLLI;
                    else if (rd_prime)
                    begin
                        if (f3 == rvcc_pkg::F3_SR)
                        begin
                            if (f7 == rvcc_pkg::F7_BASE)
                                compress_class = rvcc_pkg::CLS_SRLI;
                            else if (f7 == rvcc_pkg::F7_ALT)
                                compress_class = rvcc_pkg::CLS_SRAI;
                        end
                        else if (f3 == rvcc_pkg::F3_AND && imm_i_small)
                            compress_class = rvcc_pkg::CLS_ANDI;
                    end
                end
            end
            rvcc_pkg::OPC_LUI:
            begin
                if (rd != rvcc_pkg::REG_ZERO && rd != rvcc_pkg::REG_SP
                    && imm_u_small && !imm_u_zero)
                    compress_class = rvcc_pkg::CLS_LUI;
            end
            rvcc_pkg::OPC_LOAD:
            begin
                if (rs1_prime && rd_prime && lw_offset_ok && f3 == rvcc_pkg::F3_WORD)
                    compress_class = rvcc_pkg::CLS_LW;
            end
            rvcc_pkg::OPC_STORE:
            begin
                if (rs1_prime && rs2_prime && sw_offset_ok && f3 == rvcc_pkg::F3_WORD)
                    compress_class = rvcc_pkg::CLS_SW;
            end
            rvcc_pkg::OPC_BRANCH:
            begin
                compress_class = rvcc_pkg::CLS_BRANCH_FIX;
                if (rs2 == rvcc_pkg::REG_ZERO && rs1_prime && br_offset_ok)
                begin
                    if (f3 == rvcc_pkg::F3_BEQ)
                        compress_class = rvcc_pkg::CLS_BEQZ;
                    else if (f3 == rvcc_pkg::F3_BNE)
                        compress_class = rvcc_pkg::CLS_BNEZ;
                end
            end
            rvcc_pkg::OPC_JAL:
            begin
                compress_class = rvcc_pkg::CLS_JAL_FIX;
                if (jal_offset_ok)
                begin
                    if (rd == rvcc_pkg::REG_ZERO)
                        compress_class = rvcc_pkg::CLS_J;
                    else if (rd == rvcc_pkg::REG_RA)
                        compress_class = rvcc_pkg::CLS_JAL;
                end
            end
            default:
                compress_class = rvcc_pkg::CLS_NONE;
        endcase
    end

endmodule

### hw/rtl/rv32i_compressibility_classifier.sv
// Top level of the RVC compressibility classifier: input register, decode,
// result register. Depends on rvcc_pkg and rvcc_classify.
//
//  channel   ports                      dir   handshake
//  --------  -------------------------  ----  ----------------------------------
//  request   start, busy, instruction   in    taken when start high, busy low
//  result    done, compress_class       out   one-cycle strobe, cannot be held
//
// Each request is first captured as a word in instr_reg, then its class in
// class_reg as done rises; the receiver takes the class while done is high.
// A request can be taken on every edge; the pipeline never fills up, so
// busy stays low. Reset clears the valid flags only; the data registers
// hold whatever they last saw. The receiver cannot stall, so no results
// are held back and the pipeline just advances every cycle.
module rv32i_compressibility_classifier
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rvcc_pkg::instr_t instruction,
    output logic             done,
    output rvcc_pkg::class_t compress_class
);

    rvcc_pkg::instr_t instr_reg;
    logic             in_valid_reg;
    rvcc_pkg::class_t class_next;
    rvcc_pkg::class_t class_reg;
    logic             out_valid_reg;

    // Nothing ever backs up, so requests are always welcome
    assign busy = 1'b0;

    // Valid flags: advance every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Capture the word only when a request is taken
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            instr_reg <= instruction;
    end

    rvcc_classify u_classify
    (
        .instruction    (instr_reg),
        .compress_class (class_next)
    );

    // Result register: hold the class for its single strobe cycle
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            class_reg <= class_next;
    end

    assign done           = out_valid_reg;
    assign compress_class = class_reg;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rv32i_compressibility_classifier: directed and random
// RV32I words checked against a local decode model. Depends on rvcc_pkg and rv32i_compressibility_classifier.
module tb_top;

    // Cycles with nothing accepted on either side before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    // Random requests per idling phase
    localparam int RAND_PER_PHASE = 600;

    localparam logic [6:0] KNOWN_OPS [8] = '{rvcc_pkg::OPC_OP, rvcc_pkg::OPC_JALR,
                                             rvcc_pkg::OPC_OPIMM, rvcc_pkg::OPC_LUI,
                                             rvcc_pkg::OPC_LOAD, rvcc_pkg::OPC_STORE,
                                             rvcc_pkg::OPC_BRANCH, rvcc_pkg::OPC_JAL};

    typedef struct {
        rvcc_pkg::instr_t word;
        bit               typed;   // set where the class is written into the table
        rvcc_pkg::class_t want;
    } dir_case_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    rvcc_pkg::instr_t instruction;
    logic             done;
    rvcc_pkg::class_t compress_class;

    rvcc_pkg::class_t expected_classes[$];
    int               fail_count;
    int               sent_count;
    int               checked_count;
    int               idle_pct;
    int               quiet_cycles;
    logic [31:0]      seen_classes;

    rv32i_compressibility_classifier dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .instruction    (instruction),
        .done           (done),
        .compress_class (compress_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Instruction encoders: immediates are taken as plain integers and
    // sliced into the format's bit positions.
    // ------------------------------------------------------------------
    function automatic rvcc_pkg::instr_t r_enc(logic [6:0] f7, logic [4:0] rs2,
                                               logic [4:0] rs1, logic [2:0] f3,
                                               logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic rvcc_pkg::instr_t i_enc(int imm, logic [4:0] rs1, logic [2:0] f3,
                                               logic [4:0] rd, logic [6:0] op);
        return {imm[11:0], rs1, f3, rd, op};
    endfunction

    function automatic rvcc_pkg::instr_t s_enc(int imm, logic [4:0] rs2, logic [4:0] rs1,
                                               logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], rvcc_pkg::OPC_STORE};
    endfunction

    function automatic rvcc_pkg::instr_t b_enc(int off, logic [4:0] rs2, logic [4:0] rs1,
                                               logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11],
                rvcc_pkg::OPC_BRANCH};
    endfunction

    function automatic rvcc_pkg::instr_t u_enc(int imm, logic [4:0] rd);
        return {imm[19:0], rd, rvcc_pkg::OPC_LUI};
    endfunction

    function automatic rvcc_pkg::instr_t j_enc(int off, logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, rvcc_pkg::OPC_JAL};
    endfunction

    function automatic bit is_prime_reg(logic [4:0] r);
        return r[4:3] == 2'b01;
    endfunction

    // ------------------------------------------------------------------
    // Compression class of one word, decoded field by field.
    // ------------------------------------------------------------------
    function automatic rvcc_pkg::class_t classify_instr(rvcc_pkg::instr_t w);
        logic [6:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        int         imm_i;
        int         imm_s;
        int         imm_u;
        int         off;

        op    = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        rd    = w[11:7];
        rs1   = w[19:15];
        rs2   = w[24:20];
        imm_i = $signed(w[31:20]);
        imm_s = $signed({w[31:25], w[11:7]});
        imm_u = $signed(w[31:12]);

        case (op)
            rvcc_pkg::OPC_OP:
            begin
                if (f3 == rvcc_pkg::F3_ADD)
                begin
                    if (f7 == rvcc_pkg::F7_ALT)
                        return (is_prime_reg(rs2) && is_prime_reg(rd) && rs1 == rd)
                               ? rvcc_pkg::CLS_SUB : rvcc_pkg::CLS_NONE;
                    if (f7 != rvcc_pkg::F7_BASE || rs2 == rvcc_pkg::REG_ZERO
                        || rd == rvcc_pkg::REG_ZERO)
                        return rvcc_pkg::CLS_NONE;
                    if (rs1 == rvcc_pkg::REG_ZERO)
                        return rvcc_pkg::CLS_MV;
                    return (rs1 == rd) ? rvcc_pkg::CLS_ADD : rvcc_pkg::CLS_NONE;
                end
                if (!is_prime_reg(rs2) || !is_prime_reg(rd) || rs1 != rd
                    || f7 != rvcc_pkg::F7_BASE)
                    return rvcc_pkg::CLS_NONE;
                case (f3)
                    rvcc_pkg::F3_AND: return rvcc_pkg::CLS_AND;
                    rvcc_pkg::F3_OR:  return rvcc_pkg::CLS_OR;
                    rvcc_pkg::F3_XOR: return rvcc_pkg::CLS_XOR;
                    default:          return rvcc_pkg::CLS_NONE;
                endcase
            end
            rvcc_pkg::OPC_JALR:
            begin
                if (rs1 == rvcc_pkg::REG_ZERO || w[31:20] != 12'd0 || f3 != rvcc_pkg::F3_ADD)
                    return rvcc_pkg::CLS_NONE;
                if (rd == rvcc_pkg::REG_ZERO)
                    return rvcc_pkg::CLS_JR;
                return (rd == rvcc_pkg::REG_RA) ? rvcc_pkg::CLS_JALR : rvcc_pkg::CLS_NONE;
            end
            rvcc_pkg::OPC_OPIMM:
            begin
                if (f3 == rvcc_pkg::F3_ADD)
                begin
                    if (rd == rvcc_pkg::REG_ZERO || imm_i < -32 || imm_i > 31)
                        return rvcc_pkg::CLS_NONE;
                    if (rs1 == rvcc_pkg::REG_ZERO)
                        return rvcc_pkg::CLS_LI;
                    return (rs1 != rd || imm_i == 0) ? rvcc_pkg::CLS_NONE
                                                     : rvcc_pkg::CLS_ADDI;
                end
                if (rs1 != rd)
                    return rvcc_pkg::CLS_NONE;
                // A zero shift amount still maps onto the compressed slli hint
                if (f3 == rvcc_pkg::F3_SLL && f7 == rvcc_pkg::F7_BASE
                    && rd != rvcc_pkg::REG_ZERO)
                    return rvcc_pkg::CLS_SLLI;
                if (!is_prime_reg(rd))
                    return rvcc_pkg::CLS_NONE;
                if (f3 == rvcc_pkg::F3_SR)
                begin
                    if (f7 == rvcc_pkg::F7_BASE)
                        return rvcc_pkg::CLS_SRLI;
                    return (f7 == rvcc_pkg::F7_ALT) ? rvcc_pkg::CLS_SRAI
                                                    : rvcc_pkg::CLS_NONE;
                end
                if (f3 == rvcc_pkg::F3_AND)
                    return (imm_i < -32 || imm_i > 31) ? rvcc_pkg::CLS_NONE
                                                       : rvcc_pkg::CLS_ANDI;
                return rvcc_pkg::CLS_NONE;
            end
            rvcc_pkg::OPC_LUI:
            begin
                if (rd == rvcc_pkg::REG_ZERO || rd == rvcc_pkg::REG_SP)
                    return rvcc_pkg::CLS_NONE;
                return (imm_u < -32 || imm_u > 31 || imm_u == 0) ? rvcc_pkg::CLS_NONE
                                                                 : rvcc_pkg::CLS_LUI;
            end
            rvcc_pkg::OPC_LOAD:
            begin
                if (!is_prime_reg(rs1) || !is_prime_reg(rd))
                    return rvcc_pkg::CLS_NONE;
                if (imm_i < 0 || imm_i > 127 || imm_i[1:0] != 2'b00)
                    return rvcc_pkg::CLS_NONE;
                return (f3 == rvcc_pkg::F3_WORD) ? rvcc_pkg::CLS_LW : rvcc_pkg::CLS_NONE;
            end
            rvcc_pkg::OPC_STORE:
            begin
                if (!is_prime_reg(rs1) || !is_prime_reg(rs2))
                    return rvcc_pkg::CLS_NONE;
                if (imm_s < 0 || imm_s > 127 || imm_s[1:0] != 2'b00)
                    return rvcc_pkg::CLS_NONE;
                return (f3 == rvcc_pkg::F3_WORD) ? rvcc_pkg::CLS_SW : rvcc_pkg::CLS_NONE;
            end
            rvcc_pkg::OPC_BRANCH:
            begin
                off = $signed({w[31], w[7], w[30:25], w[11:8]});
                off = off * 2;
                if (rs2 != rvcc_pkg::REG_ZERO || !is_prime_reg(rs1) || off < -256
                    || off > 255)
                    return rvcc_pkg::CLS_BRANCH_FIX;
                if (f3 == rvcc_pkg::F3_BEQ)
                    return rvcc_pkg::CLS_BEQZ;
                return (f3 == rvcc_pkg::F3_BNE) ? rvcc_pkg::CLS_BNEZ
                                                : rvcc_pkg::CLS_BRANCH_FIX;
            end
            rvcc_pkg::OPC_JAL:
            begin
                off = $signed({w[31], w[19:12], w[20], w[30:21]});
                off = off * 2;
                if (off < -2048 || off > 2047)
                    return rvcc_pkg::CLS_JAL_FIX;
                if (rd == rvcc_pkg::REG_ZERO)
                    return rvcc_pkg::CLS_J;
                return (rd == rvcc_pkg::REG_RA) ? rvcc_pkg::CLS_JAL : rvcc_pkg::CLS_JAL_FIX;
            end
            default:
                return rvcc_pkg::CLS_NONE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random words. Most are well-formed encodings of the covered opcodes
    // with registers biased towards x0..x2 and x8..x15 and immediates
    // biased towards the compressible ranges; the rest is noise.
    // ------------------------------------------------------------------
    function automatic logic [4:0] any_reg();
        case ($urandom_range(0, 3))
            0:       return 5'($urandom_range(0, 2));
            1, 2:    return 5'(8 + $urandom_range(0, 7));
            default: return 5'($urandom);
        endcase
    endfunction

    function automatic int near(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic rvcc_pkg::instr_t random_instr();
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        logic [2:0] f3;
        logic [6:0] f7;
        int         imm;

        rd  = any_reg();
        rs1 = $urandom_range(0, 1) ? rd : any_reg();
        rs2 = any_reg();
        f3  = 3'($urandom);
        case ($urandom_range(0, 3))
            0, 1:    f7 = rvcc_pkg::F7_BASE;
            2:       f7 = rvcc_pkg::F7_ALT;
            default: f7 = 7'($urandom);
        endcase
        imm = $urandom_range(0, 3) ? near(-40, 140) : int'($urandom);
        if ($urandom_range(0, 1))
            imm = imm & ~3;

        case ($urandom_range(0, 11))
            0:
                return $urandom;
            1:
                return {25'($urandom), KNOWN_OPS[$urandom_range(0, 7)]};
            2, 3:
                return r_enc(f7, rs2, rs1, f3, rd, rvcc_pkg::OPC_OP);
            4:
                return i_enc($urandom_range(0, 3) ? 0 : imm, rs1,
                             $urandom_range(0, 3) ? rvcc_pkg::F3_ADD : f3,
                             $urandom_range(0, 1) ? 5'($urandom_range(0, 1)) : rd,
                             rvcc_pkg::OPC_JALR);
            5, 6:
            begin
                if (f3 == rvcc_pkg::F3_SLL || f3 == rvcc_pkg::F3_SR)
                    imm = int'({f7, 5'($urandom)});
                else if ($urandom_range(0, 3))
                    imm = near(-40, 40);
                return i_enc(imm, rs1, f3, rd, rvcc_pkg::OPC_OPIMM);
            end
            7:
                return u_enc($urandom_range(0, 2) ? near(-40, 40) : int'($urandom), rd);
            8:
                return i_enc(imm, rs1, $urandom_range(0, 1) ? rvcc_pkg::F3_WORD : f3, rd,
                             rvcc_pkg::OPC_LOAD);
            9:
                return s_enc(imm, rs2, rs1, $urandom_range(0, 1) ? rvcc_pkg::F3_WORD : f3);
            10:
                return b_enc($urandom_range(0, 3) ? near(-150, 150) * 2 : int'($urandom),
                             $urandom_range(0, 1) ? rvcc_pkg::REG_ZERO : rs2, rs1,
                             $urandom_range(0, 2) ? 3'($urandom_range(0, 1)) : f3);
            default:
                return j_enc($urandom_range(0, 3) ? near(-1100, 1100) * 2 : int'($urandom),
                             $urandom_range(0, 1) ? 5'($urandom_range(0, 1)) : rd);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Idle for a random number of cycles at the current
    // rate, then hold start high until an edge with busy low takes the
    // request; queue the class it must produce at that edge. start is
    // assigned once per edge, so back-to-back requests keep it high.
    // ------------------------------------------------------------------
    task automatic issue(rvcc_pkg::instr_t w, rvcc_pkg::class_t want);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        instruction <= w;
        do
            @(posedge clk);
        while (busy);
        expected_classes.push_back(want);
        sent_count++;
    endtask

    // Drop start and hold off until every queued class has come back
    task automatic drain();
        start <= 1'b0;
        while (expected_classes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done strobe must match the oldest queued class.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (expected_classes.size() == 0)
            begin
                $display("%0t: result %0d with no request outstanding", $time, compress_class);
                fail_count++;
            end
            else
            begin
                if (compress_class !== expected_classes[0])
                begin
                    $display("%0t: class mismatch, expected %0d, got %0d",
                             $time, expected_classes[0], compress_class);
                    fail_count++;
                end
                void'(expected_classes.pop_front());
                checked_count++;
                seen_classes[compress_class] <= 1'b1;
            end
        end
    end

    // Watchdog: count edges on which neither a request nor a result moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        dir_case_t        plan[$];
        rvcc_pkg::class_t want;

        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        seen_classes  = '0;
        idle_pct      = 10;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        instruction <= '0;

        // Directed rows: extremes, one of each compressed form, and the
        // special cases around branches, jal and the zero-shift slli.
        plan = '{
            '{32'h0000_0000, 1'b1, rvcc_pkg::CLS_NONE},
            '{32'hFFFF_FFFF, 1'b1, rvcc_pkg::CLS_NONE},
            '{r_enc(rvcc_pkg::F7_BASE, 5'd9, 5'd8, rvcc_pkg::F3_ADD, 5'd8,
                    rvcc_pkg::OPC_OP), 1'b0, rvcc_pkg::CLS_NONE},
            '{r_enc(rvcc_pkg::F7_BASE, 5'd6, rvcc_pkg::REG_ZERO, rvcc_pkg::F3_ADD, 5'd5,
                    rvcc_pkg::OPC_OP), 1'b0, rvcc_pkg::CLS_NONE},
            '{r_enc(rvcc_pkg::F7_ALT, 5'd9, 5'd8, rvcc_pkg::F3_ADD, 5'd8,
                    rvcc_pkg::OPC_OP), 1'b0, rvcc_pkg::CLS_NONE},
            '{r_enc(rvcc_pkg::F7_BASE, 5'd10, 5'd9, rvcc_pkg::F3_AND, 5'd9,
                    rvcc_pkg::OPC_OP), 1'b0, rvcc_pkg::CLS_NONE},
            '{r_enc(rvcc_pkg::F7_BASE, 5'd10, 5'd9, rvcc_pkg::F3_OR, 5'd9,
                    rvcc_pkg::OPC_OP), 1'b0, rvcc_pkg::CLS_NONE},
            '{r_enc(rvcc_pkg::F7_BASE, 5'd10, 5'd9, rvcc_pkg::F3_XOR, 5'd9,
                    rvcc_pkg::OPC_OP), 1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(0, 5'd5, rvcc_pkg::F3_ADD, rvcc_pkg::REG_ZERO, rvcc_pkg::OPC_JALR),
              1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(0, 5'd5, rvcc_pkg::F3_ADD, rvcc_pkg::REG_RA, rvcc_pkg::OPC_JALR),
              1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(-32, rvcc_pkg::REG_ZERO, rvcc_pkg::F3_ADD, 5'd5, rvcc_pkg::OPC_OPIMM),
              1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(31, 5'd5, rvcc_pkg::F3_ADD, 5'd5, rvcc_pkg::OPC_OPIMM),
              1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(0, 5'd5, rvcc_pkg::F3_SLL, 5'd5, rvcc_pkg::OPC_OPIMM),
              1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(int'({rvcc_pkg::F7_BASE, 5'd31}), 5'd8, rvcc_pkg::F3_SR, 5'd8,
                    rvcc_pkg::OPC_OPIMM), 1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(int'({rvcc_pkg::F7_ALT, 5'd1}), 5'd8, rvcc_pkg::F3_SR, 5'd8,
                    rvcc_pkg::OPC_OPIMM), 1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(-32, 5'd8, rvcc_pkg::F3_AND, 5'd8, rvcc_pkg::OPC_OPIMM),
              1'b0, rvcc_pkg::CLS_NONE},
            '{u_enc(-1, 5'd5), 1'b0, rvcc_pkg::CLS_NONE},
            '{i_enc(124, 5'd9, rvcc_pkg::F3_WORD, 5'd8, rvcc_pkg::OPC_LOAD),
              1'b0, rvcc_pkg::CLS_NONE},
            '{s_enc(124, 5'd9, 5'd8, rvcc_pkg::F3_WORD), 1'b0, rvcc_pkg::CLS_NONE},
            '{b_enc(-256, rvcc_pkg::REG_ZERO, 5'd8, rvcc_pkg::F3_BEQ),
              1'b0, rvcc_pkg::CLS_NONE},
            '{b_enc(254, rvcc_pkg::REG_ZERO, 5'd8, rvcc_pkg::F3_BNE),
              1'b0, rvcc_pkg::CLS_NONE},
            '{b_enc(4, 5'd9, 5'd8, rvcc_pkg::F3_BEQ), 1'b1, rvcc_pkg::CLS_BRANCH_FIX},
            '{b_enc(4, rvcc_pkg::REG_ZERO, 5'd8, 3'd4), 1'b1, rvcc_pkg::CLS_BRANCH_FIX},
            '{j_enc(-2048, rvcc_pkg::REG_ZERO), 1'b0, rvcc_pkg::CLS_NONE},
            '{j_enc(2046, rvcc_pkg::REG_RA), 1'b0, rvcc_pkg::CLS_NONE},
            '{j_enc(2048, rvcc_pkg::REG_ZERO), 1'b1, rvcc_pkg::CLS_JAL_FIX},
            '{j_enc(4, 5'd5), 1'b1, rvcc_pkg::CLS_JAL_FIX}
        };

        // Hold reset, then release it on an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            want = plan[i].typed ? plan[i].want : classify_instr(plan[i].word);
            issue(plan[i].word, want);
        end
        drain();

        // Three idling phases: light gaps, heavy gaps, then back-to-back.
        // Drain between them so the sender pauses with the pipe empty.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 10 : (phase == 1) ? 49 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                rvcc_pkg::instr_t w;
                w = random_instr();
                issue(w, classify_instr(w));
            end
            drain();
        end

        // Let the two-stage pipe settle and catch any stray strobe
        repeat (6) @(posedge clk);

        $display("Sent %0d requests (%0d directed), checked %0d classes, %0d of 24 codes seen.",
                 sent_count, plan.size(), checked_count, $countones(seen_classes));
        $display("Sender gaps ran at 10, 49 and 0 per cent, with a full drain between phases.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### rv32i_compressibility_classifier.f
hw/rtl/rvcc_pkg.sv
hw/rtl/rvcc_classify.sv
hw/rtl/rv32i_compressibility_classifier.sv
sim/tb_top.sv
